@@ rtl/core/i2d_pkg.sv @@
package i2d_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	// double-dabble shift steps done by one pipeline stage
	localparam int STEPS_PER_STAGE = 8;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// Status of the word leaving the converter.
	typedef struct packed {
		logic valid;
		logic neg;
	} conv_stat_t;

	// Decimal digits needed for the largest magnitude, 2^(w-1).
	function automatic int num_digits(input int w);
		longint unsigned v;
		int n;
		v = 64'd1 << (w - 1);
		n = 0;
		while (v != 64'd0) begin
			v = v / 10;
			n++;
		end
		return n;
	endfunction

endpackage

@@ rtl/core/int_to_decimal_ascii.sv @@
// Decimal text of a signed integer as a run of ASCII characters.
//
// Input: drive value and raise start; the word is taken at a clock edge
// where start is high and busy is low. Bit VALUE_WIDTH-1 is the sign.
// Output: one character per cycle on char_code, marked by strobe for one
// cycle; last_char marks the final character of the number. A negative
// number starts with '-', leading zeros are dropped, zero gives one '0'.
// Path: a taken word passes a magnitude stage, a double-dabble pipeline of
// eight shift steps per stage, a leading-digit stage and the character
// serializer before its first character shows.
// Throughput: one character per cycle; a word gives 1 to 11 characters at
// a width of 32. The serializer takes a new word only when idle or while
// sending the final digit, and busy rises as the pipeline fills behind it.
// Reset clears all valid bits; no character is sent after reset until a
// word is taken. The receiver cannot stall: every strobe is a delivery.
module int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = i2d_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          strobe,
	output logic [7:0]                    char_code,
	output logic                          last_char
);
	import i2d_pkg::*;

	localparam int ND = num_digits(VALUE_WIDTH);
	localparam int IW = (ND > 1) ? $clog2(ND) : 1;

	conv_stat_t        cv_stat;
	logic [4*ND-1:0]   cv_digits;
	logic [IW-1:0]     cv_lead;
	logic              cv_in_ready;
	logic              ser_ready;

	logic              active_q;
	logic              neg_pend_q;
	logic [IW-1:0]     idx_q;
	logic [4*ND-1:0]   digits_q;
	logic              strobe_q;
	logic [7:0]        char_q;
	logic              last_q;

	i2d_conv #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.ND          (ND),
		.IW          (IW)
	) u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.in_ready   (cv_in_ready),
		.in_value   (value),
		.out_ready  (ser_ready),
		.out_stat   (cv_stat),
		.out_digits (cv_digits),
		.out_lead   (cv_lead)
	);

	assign busy = !cv_in_ready;

	// free when idle or sending the final digit this cycle
	assign ser_ready = !active_q || (!neg_pend_q && idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			neg_pend_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (active_q && neg_pend_q) begin
				neg_pend_q <= 1'b0;
			end else if (ser_ready) begin
				active_q   <= cv_stat.valid;
				neg_pend_q <= cv_stat.valid && cv_stat.neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			if (neg_pend_q) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + {4'd0, digits_q[4*idx_q +: 4]};
				last_q <= (idx_q == '0);
			end
		end
		if (active_q && !neg_pend_q && idx_q != '0) begin
			idx_q <= idx_q - IW'(1);
		end else if (ser_ready && cv_stat.valid) begin
			idx_q    <= cv_lead;
			digits_q <= cv_digits;
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last_char = last_q;

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && char_code == CHAR_MINUS |-> !last_char)
		else $error("minus sign marked as last character");

	a_minus_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && char_code == CHAR_MINUS |=> strobe && char_code != CHAR_MINUS)
		else $error("minus sign not followed at once by a digit");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> char_code == CHAR_MINUS
			|| (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 8'd9))
		else $error("character outside minus and digits");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_char |=> strobe)
		else $error("gap inside a character run");

endmodule

@@ rtl/core/i2d_conv.sv @@
module i2d_conv #(
	parameter int VALUE_WIDTH = i2d_pkg::VALUE_WIDTH_DEF,
	parameter int ND = i2d_pkg::num_digits(i2d_pkg::VALUE_WIDTH_DEF),
	parameter int IW = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [VALUE_WIDTH-1:0]   in_value,
	input  logic                     out_ready,
	output i2d_pkg::conv_stat_t      out_stat,
	output logic [4*ND-1:0]          out_digits,
	output logic [IW-1:0]            out_lead
);
	import i2d_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int BW = 4 * ND;
	localparam int CW = BW + W;
	localparam int NS = (W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	// stage 0 takes the magnitude, 1..NS convert, NS+1 finds the leading digit
	localparam int NP = NS + 2;

	logic            vld_s [NP];
	logic            neg_s [NP];
	logic [W-1:0]    bin_s [NS+1];
	logic [BW-1:0]   bcd_s [NP];
	logic [IW-1:0]   lead_s;
	logic            rdy   [NP+1];

	assign rdy[NP] = out_ready;

	genvar k;
	generate
		for (k = 0; k < NP; k++) begin : g_rdy
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end
	endgenerate

	assign in_ready = rdy[0];

	// magnitude stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			neg_s[0] <= in_value[W-1];
			bin_s[0] <= in_value[W-1] ? (~in_value + W'(1)) : in_value;
			bcd_s[0] <= '0;
		end
	end

	generate
		for (k = 1; k <= NS; k++) begin : g_dabble
			localparam int BASE = (k - 1) * STEPS_PER_STAGE;
			logic [CW-1:0] t;

			always_comb begin
				t = {bcd_s[k-1], bin_s[k-1]};
				for (int j = 0; j < STEPS_PER_STAGE; j++) begin
					if (BASE + j < W) begin
						for (int d = 0; d < ND; d++) begin
							if (t[W+4*d +: 4] >= 4'd5) begin
								t[W+4*d +: 4] = t[W+4*d +: 4] + 4'd3;
							end
						end
						t = t << 1;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && vld_s[k-1]) begin
					neg_s[k] <= neg_s[k-1];
					bin_s[k] <= t[W-1:0];
					bcd_s[k] <= t[CW-1:W];
				end
			end
		end
	endgenerate

	// leading nonzero digit; zero prints from digit 0
	logic [IW-1:0] lead_d;

	always_comb begin
		lead_d = '0;
		for (int d = 0; d < ND; d++) begin
			if (bcd_s[NS][4*d +: 4] != 4'd0) begin
				lead_d = IW'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[NS+1] <= 1'b0;
		end else if (rdy[NS+1]) begin
			vld_s[NS+1] <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NS+1] && vld_s[NS]) begin
			neg_s[NS+1] <= neg_s[NS];
			bcd_s[NS+1] <= bcd_s[NS];
			lead_s      <= lead_d;
		end
	end

	assign out_stat.valid = vld_s[NS+1];
	assign out_stat.neg   = neg_s[NS+1];
	assign out_digits     = bcd_s[NS+1];
	assign out_lead       = lead_s;

endmodule

@@ bench/tb_int_to_decimal_ascii.sv @@
`timescale 1ns / 100ps

typedef struct packed {
	logic [7:0] code;
	logic       last;
} text_char_t;

class decimal_text_scoreboard;
	localparam int W = i2d_pkg::VALUE_WIDTH_DEF;

	text_char_t pending_text[$];
	int mismatches;
	int words_noted;
	int chars_checked;
	int negatives_noted;

	function new();
		mismatches = 0;
		words_noted = 0;
		chars_checked = 0;
		negatives_noted = 0;
	endfunction

	// Append the decimal text of one accepted word to the pending characters.
	function void note_word(logic [W-1:0] raw);
		logic       neg;
		logic [W:0] mag;
		logic [3:0] digs[$];
		text_char_t c;
		neg = raw[W-1];
		// widen before negating so the most negative value keeps its magnitude
		mag = neg ? (({1'b1, {W{1'b0}}}) - {1'b0, raw}) : {1'b0, raw};
		do begin
			digs.push_front(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (neg) begin
			c.code = i2d_pkg::CHAR_MINUS;
			c.last = 1'b0;
			pending_text.push_back(c);
			negatives_noted++;
		end
		foreach (digs[i]) begin
			c.code = i2d_pkg::CHAR_ZERO + 8'(digs[i]);
			c.last = (i == digs.size() - 1);
			pending_text.push_back(c);
		end
		words_noted++;
	endfunction

	function void check_char(logic [7:0] code, logic last);
		text_char_t want;
		chars_checked++;
		if (pending_text.size() == 0) begin
			$error("unexpected char: char_code %0d last_char %0b", code, last);
			mismatches++;
			return;
		end
		want = pending_text.pop_front();
		if (code !== want.code) begin
			$error("char_code: expected %0d, got %0d", want.code, code);
			mismatches++;
		end
		if (last !== want.last) begin
			$error("last_char: expected %0b, got %0b", want.last, last);
			mismatches++;
		end
	endfunction

	function int pending();
		return pending_text.size();
	endfunction

	function void report_leftover();
		if (pending_text.size() != 0) begin
			$error("%0d chars never arrived", pending_text.size());
			mismatches++;
		end
	endfunction
endclass

module tb_int_to_decimal_ascii;
	localparam int W = i2d_pkg::VALUE_WIDTH_DEF;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic signed [W-1:0] value = '0;
	logic                busy;
	logic                strobe;
	logic [7:0]          char_code;
	logic                last_char;

	decimal_text_scoreboard sb = new();

	int burst_left;

	int directed_values[] = '{
		0, 1, -1, 5, -9, 9, 10, -10, 99, 100, -100, 12345, -67890,
		999999999, 1000000000, -1000000000, 1999999999, -1999999999,
		2147483647, -2147483647, -2147483647 - 1, 32'h55555555, 32'hAAAAAAAA,
		-2147483638, 2147483640
	};

	int_to_decimal_ascii uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_char(char_code, last_char);
	end

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [W-1:0] v);
		logic taken;
		start <= 1'b1;
		value <= v;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1'b1;
				sb.note_word(v);
			end
			@(negedge clk);
		end
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		value <= $urandom;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [W-1:0] pick_value();
		int         mode;
		int         nd;
		longint     lo;
		longint     hi;
		longint     mag;
		logic [W-1:0] v;
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1, 2, 3: begin
				v = $urandom;
			end
			4, 5, 6: begin
				// pick a digit count first so every text length is common
				nd = $urandom_range(1, 10);
				lo = 1;
				repeat (nd - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (nd == 1)
					lo = 0;
				if (hi > 64'd2147483647)
					hi = 64'd2147483647;
				mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
				v = W'(mag);
				if ($urandom_range(0, 1))
					v = -v;
			end
			7: begin
				v = W'($urandom_range(0, 40)) - W'(20);
			end
			8: begin
				v = $urandom_range(0, 1) ? (32'h7FFFFFFF - $urandom_range(0, 15))
				                         : (32'h80000000 + $urandom_range(0, 15));
			end
			default: begin
				nd = $urandom_range(0, 9);
				mag = 1;
				repeat (nd) mag = mag * 10;
				v = W'(mag + longint'($urandom_range(0, 2)) - 1);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin
		int guard;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_values[i])
			send_word(directed_values[i]);
		idle_cycles(20);

		burst_left = 0;
		for (int k = 0; k < 300; k++) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) != 0)
					idle_cycles($urandom_range(1, 14));
				burst_left = $urandom_range(1, 16);
			end
			send_word(pick_value());
			burst_left--;
		end
		idle_cycles(1);

		guard = 0;
		while (sb.pending() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		// hold a while longer to catch stray chars
		repeat (30) @(posedge clk);
		sb.report_leftover();

		$display("converted %0d words (%0d negative) into %0d chars",
			sb.words_noted, sb.negatives_noted, sb.chars_checked);
		$display("mismatches found: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb_int_to_decimal_ascii passed");
		else
			$display("tb_int_to_decimal_ascii failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_int_to_decimal_ascii failed");
		$finish;
	end

endmodule
